[hw/rtl/bqf_pkg.sv]
// Shared types and constants for the biquad IIR filter.
package bqf_pkg;

  // Configuration register indexes, in register map order.
  typedef enum logic [2:0] {
    REG_SCALE = 3'd0,
    REG_A0    = 3'd1,
    REG_A1    = 3'd2,
    REG_A2    = 3'd3,
    REG_B1    = 3'd4,
    REG_B2    = 3'd5
  } reg_idx_t;

  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;

  // Integer bits of a coefficient: three integer bits and the sign; the rest are fraction bits.
  localparam int COEF_INT_BITS = 4;

  // Sample operand of the shared multiplier.
  typedef enum logic [1:0] {
    OPA_X,
    OPA_D1,
    OPA_D2,
    OPA_W
  } opa_sel_t;

  // Accumulator operation on the rounded product.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // Sequencer states: idle, one per multiplier slot, then finish and output.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MB1,
    ST_MB2,
    ST_MA1,
    ST_MA2,
    ST_MA0,
    ST_FIN,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     x_load;
    opa_sel_t mul_a;
    reg_idx_t mul_b;
    acc_op_t  acc_op;
    logic     w_load;
    logic     y_load;
  } dp_cmd_t;

endpackage

[hw/rtl/bqf_ctrl.sv]
// Sequencer for the biquad filter: schedules the six products on one multiplier.
module bqf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bqf_pkg::dp_cmd_t cmd
);
  import bqf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  // The output register may be refilled when it is empty or being drained.
  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MB1;
      ST_MB1:  state_nxt = ST_MB2;
      ST_MB2:  state_nxt = ST_MA1;
      ST_MA1:  state_nxt = ST_MA2;
      ST_MA2:  state_nxt = ST_MA0;
      ST_MA0:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (can_load) begin
          state_nxt = in_valid ? ST_MX : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.x_load = 1'b0;
    cmd.mul_a  = OPA_X;
    cmd.mul_b  = REG_SCALE;
    cmd.acc_op = ACC_HOLD;
    cmd.w_load = 1'b0;
    cmd.y_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.x_load = in_valid;
      end
      ST_MX: begin
        cmd.mul_a = OPA_X;
        cmd.mul_b = REG_SCALE;
      end
      ST_MB1: begin
        cmd.acc_op = ACC_LOAD;
        cmd.mul_a  = OPA_D1;
        cmd.mul_b  = REG_B1;
      end
      ST_MB2: begin
        cmd.acc_op = ACC_SUB;
        cmd.mul_a  = OPA_D2;
        cmd.mul_b  = REG_B2;
      end
      ST_MA1: begin
        cmd.acc_op = ACC_SUB;
        cmd.mul_a  = OPA_D1;
        cmd.mul_b  = REG_A1;
      end
      ST_MA2: begin
        cmd.w_load = 1'b1;
        cmd.acc_op = ACC_LOAD;
        cmd.mul_a  = OPA_D2;
        cmd.mul_b  = REG_A2;
      end
      ST_MA0: begin
        cmd.acc_op = ACC_ADD;
        cmd.mul_a  = OPA_W;
        cmd.mul_b  = REG_A0;
      end
      ST_FIN: begin
        cmd.acc_op = ACC_ADD;
      end
      ST_OUT: begin
        cmd.y_load = can_load;
        in_ready   = can_load;
        cmd.x_load = can_load && in_valid;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.y_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/bqf_dp.sv]
// Datapath for the biquad filter: coefficient registers, delays, multiplier, accumulator.
module bqf_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data,
  input  logic [SAMPLE_WIDTH-1:0]        sample_in,
  input  bqf_pkg::dp_cmd_t               cmd,
  output logic [SAMPLE_WIDTH-1:0]        sample_out
);
  import bqf_pkg::*;

  localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
  localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int RND_W     = PROD_W - COEF_FRAC;
  localparam int ACC_W     = SAMPLE_WIDTH + 5;

  localparam logic [COEF_WIDTH-1:0] COEF_ONE =
    {{(COEF_INT_BITS - 1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF_LSB =
    PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [COEF_WIDTH-1:0]   coef_r [NUM_REGS];
  logic signed [SAMPLE_WIDTH-1:0] x_r, d1_r, d2_r, w_r, y_r;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEF_WIDTH-1:0]   mul_b;
  logic signed [PROD_W-1:0]       prod_half;
  logic signed [RND_W-1:0]        prod_rnd;
  logic signed [ACC_W-1:0]        rnd_ext;
  logic signed [SAMPLE_WIDTH-1:0] acc_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == int'(REG_SCALE) || i == int'(REG_A0)) begin
          coef_r[i] <= COEF_ONE;
        end else begin
          coef_r[i] <= '0;
        end
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_a)
      OPA_X:   mul_a = x_r;
      OPA_D1:  mul_a = d1_r;
      OPA_D2:  mul_a = d2_r;
      OPA_W:   mul_a = w_r;
      default: mul_a = x_r;
    endcase
  end

  assign mul_b    = coef_r[cmd.mul_b];
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round half up, then drop the coefficient fraction bits.
  assign prod_half = prod_r + HALF_LSB;
  assign prod_rnd  = prod_half[PROD_W-1:COEF_FRAC];
  assign rnd_ext   = ACC_W'(prod_rnd);

  always_comb begin
    case (cmd.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = rnd_ext;
      ACC_ADD:  acc_nxt = acc_r + rnd_ext;
      ACC_SUB:  acc_nxt = acc_r - rnd_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      acc_sat = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (acc_r < SAT_LO) begin
      acc_sat = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      acc_sat = acc_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.x_load) begin
      x_r <= sample_in;
    end
    if (cmd.w_load) begin
      w_r <= acc_sat;
    end
    if (cmd.y_load) begin
      y_r <= acc_sat;
    end
  end

  // Filter state shifts when the result is committed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (cmd.y_load) begin
      d1_r <= w_r;
      d2_r <= d1_r;
    end
  end

  assign sample_out = y_r;

endmodule

[hw/rtl/biquad_iir_filter.sv]
// Top level of the direct-form-II biquad filter section.
//
//   Channel  Direction  Beat contents
//   in_*     input      in_sample_in: signed Q1.23 sample
//   out_*    output     out_sample_out: filtered, saturated Q1.23 sample
//   cfg_*    input      cfg_index and cfg_data: one coefficient register write
//
// Each sample issues the six products through the single shared multiplier, then adds
// the last rounded product, and then saturates the sum into the output register.
// A new input beat is taken in the cycle the previous result enters the output
// register, so back-to-back samples need no idle state between them.
// A stalled output holds the sequencer in its last state until the beat is taken.
// Synchronous active-low reset restores the coefficient defaults and clears the delays.
module biquad_iir_filter #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_WIDTH-1:0]       in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_WIDTH-1:0]       out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bqf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]         cfg_data
);
  import bqf_pkg::*;

  dp_cmd_t cmd;

  // Register writes are always accepted; indexes past the map are dropped.
  assign cfg_ready = 1'b1;

  // The controller owns the handshakes and the multiplier schedule.
  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the coefficients, the two delays and the arithmetic.
  bqf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (in_sample_in),
    .cmd        (cmd),
    .sample_out (out_sample_out)
  );

endmodule

[tb/sv/biquad_iir_filter_tb.sv]
// Self-checking testbench for the biquad IIR filter section with a built-in predictor.
module biquad_iir_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqf_pkg::*;

  // The block is built at its default widths. Coefficients carry three integer
  // bits and a sign, so products are shifted right by the remaining fraction bits.
  localparam int SW   = 24;
  localparam int CW   = 24;
  localparam int FRAC = CW - COEF_INT_BITS;

  localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_MAX   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COEF_MIN   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] COEF_ONE   = CW'(1) << FRAC;

  // Register indexes past the end of the map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

  localparam int CYCLES_PER_SAMPLE = 8;
  localparam int HOLD_CYCLES       = 300;
  localparam int NUM_PHASES        = 20;
  localparam int PHASE_LEN         = 100;
  localparam int MAX_GAP           = 15;

  // Clock, reset and the three channels of the block.
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [SW-1:0]        in_sample_in;
  logic                 out_valid;
  logic                 out_ready;
  logic [SW-1:0]        out_sample_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;

  biquad_iir_filter #(
    .SAMPLE_WIDTH(SW),
    .COEF_WIDTH  (CW)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // One filtered sample that the block owes us. Directed rows may also pin the
  // value by hand, which cross-checks the predictor itself.
  typedef struct {
    logic [SW-1:0] sample_out;
    bit            pinned;
    logic [SW-1:0] pinned_value;
  } owed_sample_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One line of the directed table: either a register write or a sample.
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [SW-1:0]        data;
    bit                   pinned;
    logic [SW-1:0]        want;
  } row_t;

  // Predictor state: its own copy of the coefficient registers and of the two
  // delay taps of the direct-form-II section.
  longint coef_q [NUM_REGS];
  longint tap_one;
  longint tap_two;

  owed_sample_t owed_samples [$];
  int           fail_count;

  // Knobs shared between the stimulus sequence, the receiver and the scoreboard.
  bit            send_quiet;
  bit            recv_quiet;
  bit            hold_request;
  bit            pin_next;
  logic [SW-1:0] pin_value;

  // Free-running clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit: several times the slowest legal run of all beats with maximum
  // gaps and stalls on both sides, plus the long receiver hold.
  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  // Exact product of a sample and a Q3.20 coefficient, rounded half up to the
  // sample format. The arithmetic shift on a signed value is a floor.
  function automatic longint round_product(longint smp, longint coef);
    longint prod;
    prod = smp * coef + (longint'(1) << (FRAC - 1));
    return prod >>> FRAC;
  endfunction

  function automatic longint clamp_sample(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Runs one sample through the section: the feedback sum forms w, the
  // feedforward sum forms y, and then the delay line shifts by one.
  function automatic logic [SW-1:0] filter_sample(logic [SW-1:0] x_bits);
    longint x;
    longint w;
    longint y;
    x = longint'($signed(x_bits));
    w = round_product(x, coef_q[REG_SCALE]) - round_product(tap_one, coef_q[REG_B1])
        - round_product(tap_two, coef_q[REG_B2]);
    w = clamp_sample(w);
    y = round_product(w, coef_q[REG_A0]) + round_product(tap_one, coef_q[REG_A1])
        + round_product(tap_two, coef_q[REG_A2]);
    y = clamp_sample(y);
    tap_two = tap_one;
    tap_one = w;
    return y[SW-1:0];
  endfunction

  // Everything is sampled at the rising edge, where the inputs driven at the
  // previous falling edge are stable. Results are checked before the sample
  // accepted in the same cycle is predicted; it cannot be the one leaving.
  always @(posedge clk) begin : scoreboard
    owed_sample_t head;
    owed_sample_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          $error("out beat with no sample owed: sample_out actual %h", out_sample_out);
          fail_count++;
        end else begin
          head = owed_samples.pop_front();
          if (out_sample_out !== head.sample_out) begin
            $error("sample_out mismatch: expected %h, actual %h",
                   head.sample_out, out_sample_out);
            fail_count++;
          end
          if (head.pinned && out_sample_out !== head.pinned_value) begin
            $error("sample_out mismatch against table: expected %h, actual %h",
                   head.pinned_value, out_sample_out);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.sample_out   = filter_sample(in_sample_in);
        fresh.pinned       = pin_next;
        fresh.pinned_value = pin_value;
        owed_samples.push_back(fresh);
      end
      // Writes past the end of the register map leave the predictor untouched.
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        coef_q[cfg_index] = longint'($signed(cfg_data));
    end
  end

  // Result receiver. Before each beat it keeps ready low for a random number of
  // cycles, unless a quiet stretch is on. A hold request turns one of those
  // waits into a long stall so the block fills up and pushes back on its input.
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one sample after a random gap and holds it until accepted. With no
  // gap, valid simply stays high into the next beat.
  task automatic send_sample(logic [SW-1:0] smp, bit pin, logic [SW-1:0] want);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    pin_next  = pin;
    pin_value = want;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every owed sample has come out, then lets the sequencer run
  // out its last cycles, so that a register write lands on an idle block.
  task automatic drain_results();
    while (owed_samples.size() != 0) @(posedge clk);
    repeat (CYCLES_PER_SAMPLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficient for a random phase. Wild values mostly drive the section into
  // saturation; tame ones keep gain near one and the poles near the unit
  // circle, so the delays carry long, unsaturated responses.
  function automatic logic [CW-1:0] pick_coef(reg_idx_t idx);
    logic [CW-1:0] pick;
    case ($urandom_range(0, 3))
      0: pick = CW'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0: pick = COEF_MAX;
          1: pick = COEF_MIN;
          2: pick = '0;
          3: pick = COEF_ONE;
          4: pick = CW'(1);
          default: pick = '1;
        endcase
      end
      default: begin
        case (idx)
          REG_B1:  pick = CW'($urandom_range(0, 2 * 2 ** (FRAC + 1))) - CW'(2 ** (FRAC + 1));
          REG_B2:  pick = CW'($urandom_range(0, 2 ** FRAC - 2 ** (FRAC - 4)));
          default: pick = CW'($urandom_range(0, 2 ** (FRAC + 1))) - CW'(2 ** FRAC);
        endcase
      end
    endcase
    return pick;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] pick;
    case ($urandom_range(0, 7))
      0, 1, 2: pick = SW'($urandom);
      3, 4:    pick = SW'($urandom_range(0, 2 ** (SW - 4))) - SW'(2 ** (SW - 5));
      5:       pick = SW'($urandom_range(0, 4095)) - SW'(2048);
      6:       pick = '0;
      default: pick = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    endcase
    return pick;
  endfunction

  initial begin : stimulus
    row_t     directed_rows [0:41];
    reg_idx_t ridx;
    logic [CW-1:0] val;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    send_quiet   = 1'b0;
    recv_quiet   = 1'b0;
    hold_request = 1'b0;
    pin_next     = 1'b0;
    pin_value    = '0;
    fail_count   = 0;

    // Predictor starts from the register defaults: unity scale and unity a0,
    // everything else zero, both delays cleared.
    foreach (coef_q[i]) coef_q[i] = 0;
    coef_q[REG_SCALE] = longint'(COEF_ONE);
    coef_q[REG_A0]    = longint'(COEF_ONE);
    tap_one = 0;
    tap_two = 0;

    // Directed table. Right after reset the section is a plain wire, so the
    // first samples come straight back. A gain of +8 or -8 saturates at both
    // ends. The spare-index writes must not disturb the scale, which the next
    // sample shows. A gain of one half exposes the round-half-up rule on odd
    // inputs. Then every coefficient goes to an extreme with the feedback
    // saturating w, and finally a lightly damped resonator rings out.
    directed_rows = '{
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b1, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MAX, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b1, SAMPLE_MIN},
      '{ROW_SAMPLE, REG_SCALE,    24'h000001, 1'b1, 24'h000001},
      '{ROW_SAMPLE, REG_SCALE,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
      '{ROW_WRITE,  REG_SCALE,    COEF_MAX,   1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MAX, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b1, SAMPLE_MIN},
      '{ROW_WRITE,  REG_SCALE,    COEF_MIN,   1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MAX, 1'b1, SAMPLE_MIN},
      '{ROW_WRITE,  IDX_SPARE_LO, 24'h000000, 1'b0, 24'h000000},
      '{ROW_WRITE,  IDX_SPARE_HI, 24'hFFFFFF, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000001, 1'b1, 24'hFFFFF8},
      '{ROW_WRITE,  REG_SCALE,    24'h080000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000001, 1'b1, 24'h000001},
      '{ROW_SAMPLE, REG_SCALE,    24'hFFFFFF, 1'b1, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000003, 1'b1, 24'h000002},
      '{ROW_SAMPLE, REG_SCALE,    24'hFFFFFD, 1'b1, 24'hFFFFFF},
      '{ROW_WRITE,  REG_A0,       COEF_MAX,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_A1,       COEF_MIN,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_A2,       COEF_MAX,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_B1,       COEF_MIN,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_B2,       COEF_MAX,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_SCALE,    COEF_MAX,   1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MAX, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h123456, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b0, 24'h000000},
      '{ROW_WRITE,  REG_A0,       COEF_ONE,   1'b0, 24'h000000},
      '{ROW_WRITE,  REG_A1,       24'h000000, 1'b0, 24'h000000},
      '{ROW_WRITE,  REG_A2,       24'h000000, 1'b0, 24'h000000},
      '{ROW_WRITE,  REG_B1,       24'hE33333, 1'b0, 24'h000000},
      '{ROW_WRITE,  REG_B2,       24'h0E6666, 1'b0, 24'h000000},
      '{ROW_WRITE,  REG_SCALE,    24'h010000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MAX, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    SAMPLE_MIN, 1'b0, 24'h000000},
      '{ROW_SAMPLE, REG_SCALE,    24'h000000, 1'b0, 24'h000000}
    };

    // Synchronous reset held low, then released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        idle_input();
        drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].data, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    // Random phases. Each one starts on a drained block (the sender pauses
    // until every owed sample is back), reprograms all six registers and then
    // streams samples. The first two phases put every register at its top and
    // bottom extreme. Some phases run one or both sides without gaps, and one
    // phase has the receiver stall for a long stretch under a steady sender.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_input();
      drain_results();
      for (int r = 0; r < NUM_REGS; r++) begin
        ridx = reg_idx_t'(r);
        if (ph == 0) val = COEF_MAX;
        else if (ph == 1) val = COEF_MIN;
        else val = pick_coef(ridx);
        write_reg(ridx, val);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, CW'($urandom));
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if (ph == 4) begin
        send_quiet   = 1'b1;
        hold_request = 1'b1;
      end
      repeat (PHASE_LEN) send_sample(pick_sample(), 1'b0, '0);
    end

    // Let the last samples come out, then watch a while longer for any stray
    // beat before giving the verdict.
    idle_input();
    while (owed_samples.size() != 0) @(posedge clk);
    repeat (4 * CYCLES_PER_SAMPLE) @(posedge clk);

    if (fail_count == 0 && owed_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
